// ===== src/jse_pkg.sv =====
// Package for the JSON string escaper: item types, queue entry and escape helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

  localparam int unsigned CountW   = 24;  // output count and index width
  localparam int unsigned PosW     = 3;   // position within one escape (0..5)
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [CountW-1:0] CapReset = CountW'(1024);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] HexAlphaOfs = 8'h57;  // 'a' - 10

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,  // byte passes through
    KIND_SHORT = 2'd1,  // backslash + one letter
    KIND_UNI   = 2'd2   // \u00hh
  } jse_kind_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       last_byte;
  } jse_in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [CountW-1:0] out_index;
    logic              kept;
    logic              run_end;
    logic [CountW-1:0] total_written;
    logic [CountW-1:0] terminator_index;
  } jse_out_t;

  // One classified source byte, waiting for expansion.
  typedef struct packed {
    logic [7:0]        src_byte;
    jse_kind_e         kind;
    logic [CountW-1:0] base;
    logic              keep;
    logic [CountW-1:0] total;
    logic [CountW-1:0] term;
  } jse_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } jse_qstat_t;

  function automatic jse_kind_e classify(input logic [7:0] b);
    jse_kind_e k;
    case (b) inside
      8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, ChQuote, ChBackslash: k = KIND_SHORT;
      [8'h00:8'h1F]:                                            k = KIND_UNI;
      default:                                                  k = KIND_PLAIN;
    endcase
    return k;
  endfunction

  function automatic logic [PosW-1:0] last_pos(input jse_kind_e k);
    logic [PosW-1:0] p;
    case (k)
      KIND_SHORT: p = PosW'(1);
      KIND_UNI:   p = PosW'(5);
      default:    p = PosW'(0);
    endcase
    return p;
  endfunction

  function automatic logic [7:0] short_letter(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'h08:   c = ChB;
      8'h09:   c = ChT;
      8'h0A:   c = ChN;
      8'h0C:   c = ChF;
      8'h0D:   c = ChR;
      default: c = b;  // quote and backslash repeat themselves
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = ChZero + {4'b0, nib};
    else             c = HexAlphaOfs + {4'b0, nib};
    return c;
  endfunction

  function automatic logic [7:0] esc_byte(input logic [7:0] b, input jse_kind_e k,
                                          input logic [PosW-1:0] pos);
    logic [7:0] c;
    case (k)
      KIND_SHORT: c = (pos == '0) ? ChBackslash : short_letter(b);
      KIND_UNI: begin
        case (pos)
          PosW'(0): c = ChBackslash;
          PosW'(1): c = ChU;
          PosW'(4): c = hex_lower(b[7:4]);
          PosW'(5): c = hex_lower(b[3:0]);
          default:  c = ChZero;
        endcase
      end
      default: c = b;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/jse_front.sv =====
// Front end: accepts source bytes, classifies them, keeps the running output count
// and the capacity register, and pushes one entry per byte. Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [jse_pkg::CountW-1:0] cfg_wdata_i,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  jse_pkg::jse_in_t          in_item_i,
  input  jse_pkg::jse_qstat_t       qstat_i,
  output logic                      push_o,
  output jse_pkg::jse_entry_t       entry_o
);

  localparam int unsigned W = jse_pkg::CountW;

  logic [W-1:0] count_q, count_d;
  logic [W-1:0] cap_m1_q;   // capacity minus one
  logic         cap_zero_q;

  jse_pkg::jse_kind_e kind;
  logic [W:0]         sum;
  logic [W-1:0]       total;
  logic               keep;
  logic [W-1:0]       term;

  always_comb begin
    kind  = jse_pkg::classify(in_item_i.src_byte);
    sum   = {1'b0, count_q} + (W+1)'(jse_pkg::last_pos(kind)) + (W+1)'(1);
    total = sum[W] ? '1 : sum[W-1:0];
    if (cap_zero_q) begin
      keep = 1'b0;
    end else if (kind == jse_pkg::KIND_PLAIN) begin
      keep = count_q < cap_m1_q;
    end else begin
      keep = sum <= {1'b0, cap_m1_q};
    end
    if (cap_zero_q) begin
      term = '0;
    end else begin
      term = (total < cap_m1_q) ? total : cap_m1_q;
    end

    in_ready_o = !qstat_i.full;
    push_o     = in_valid_i && in_ready_o;

    entry_o.src_byte = in_item_i.src_byte;
    entry_o.kind     = kind;
    entry_o.base     = count_q;
    entry_o.keep     = keep;
    entry_o.total    = total;
    entry_o.term     = term;

    count_d = count_q;
    if (push_o) begin
      count_d = in_item_i.last_byte ? '0 : total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      cap_m1_q   <= jse_pkg::CapReset - W'(1);
      cap_zero_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_m1_q   <= cfg_wdata_i - W'(1);
        cap_zero_q <= (cfg_wdata_i == '0);
      end
    end
  end

  // zero capacity is the only way the stored limit wraps to all ones
  a_cap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_zero_q == (cap_m1_q == '1))
    else $error("capacity zero flag out of step with limit");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && qstat_i.full))
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== src/jse_queue.sv =====
// Short entry queue between front and back end, flop based.
// Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jse_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  jse_pkg::jse_entry_t  entry_i,
  input  wire                  pop_i,
  output jse_pkg::jse_entry_t  head_o,
  output jse_pkg::jse_qstat_t  qstat_o
);

  jse_pkg::jse_entry_t             mem_q [jse_pkg::QDepth];
  logic [jse_pkg::QPtrW-1:0]       wr_q, rd_q;
  logic [jse_pkg::QCntW-1:0]       cnt_q, cnt_d;

  always_comb begin
    qstat_o.full  = (cnt_q == jse_pkg::QCntW'(jse_pkg::QDepth));
    qstat_o.empty = (cnt_q == '0);
    head_o        = mem_q[rd_q];
    cnt_d         = cnt_q + jse_pkg::QCntW'(push_i) - jse_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + jse_pkg::QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + jse_pkg::QPtrW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= jse_pkg::QCntW'(jse_pkg::QDepth))
    else $error("queue count past depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && qstat_o.empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== src/jse_back.sv =====
// Back end: expands the head entry into 1, 2 or 6 output bytes into an output register.
// Depends on jse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  jse_pkg::jse_entry_t  head_i,
  input  jse_pkg::jse_qstat_t  qstat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output jse_pkg::jse_out_t    out_item_o
);

  localparam int unsigned W = jse_pkg::CountW;

  logic [jse_pkg::PosW-1:0] pos_q, pos_d;
  logic                     out_valid_q, out_valid_d;
  jse_pkg::jse_out_t        out_q, out_d;

  logic                     load, fire, at_end;
  logic [jse_pkg::PosW-1:0] lp;
  logic [W:0]               idx_sum;

  always_comb begin
    load    = !out_valid_q || out_ready_i;
    fire    = load && !qstat_i.empty;
    lp      = jse_pkg::last_pos(head_i.kind);
    at_end  = (pos_q == lp);
    idx_sum = {1'b0, head_i.base} + (W+1)'(pos_q);

    out_d.out_byte         = jse_pkg::esc_byte(head_i.src_byte, head_i.kind, pos_q);
    out_d.out_index        = idx_sum[W] ? '1 : idx_sum[W-1:0];
    out_d.kept             = head_i.keep;
    out_d.run_end          = at_end;
    out_d.total_written    = head_i.total;
    out_d.terminator_index = head_i.term;

    pop_o       = fire && at_end;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      pos_d       = at_end ? '0 : pos_q + jse_pkg::PosW'(1);
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // mid-escape the head entry must still be present
  a_pos_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> !qstat_i.empty)
    else $error("escape position without head entry");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qstat_i.empty |-> (pos_q <= lp))
    else $error("escape position past its length");

endmodule

`default_nettype wire

// ===== src/json_string_escaper_top.sv =====
// Top level of the JSON string escaper: front end, entry queue and back end.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// ------    ---------  ----------------------  -----------------------------------
// in        input      in_valid_i/in_ready_o   in_item_i  (src_byte, last_byte)
// out       output     out_valid_o/out_ready_i out_item_o (byte, index, kept, ...)
// cfg       input      cfg_we_i (no wait)      cfg_wdata_i (dst_capacity)
//
// A source item is classified and its count updated in the cycle it is taken; the
// front takes one item per cycle while the 4-entry queue has room.
// The back end sends one output item per cycle unless out_ready_i or an empty queue
// holds it: a plain byte gives 1 item, a short escape 2 and a \u00hh escape 6, so
// escapes set the sustained drain rate; results sit in a registered output stage.
// Reset (async, active low) clears the count, the queue and the output valid, and
// sets the capacity to 1024; there is no clearing pass.
// Each side stalls on its own: out_ready_i low holds the output register, a full
// queue drops in_ready_o.

module json_string_escaper_top (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [jse_pkg::CountW-1:0] cfg_wdata_i,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  jse_pkg::jse_in_t          in_item_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output jse_pkg::jse_out_t         out_item_o
);

  jse_pkg::jse_qstat_t qstat;
  jse_pkg::jse_entry_t entry, head;
  logic                push, pop;

  // classification, running count, capacity register
  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (entry)
  );

  // decouples byte intake from escape expansion
  jse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // one output byte per cycle unless out_ready_i or an empty queue holds it, entry popped on its final byte
  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
